FILE: src/fss_pkg.sv
// ============================================================================
// fss_pkg - shared types and constants for the flagged segment statistics
// Widths of the accumulators, divider sizing, controller state encoding and
// the command/status bundles between controller and datapath.
// ============================================================================
package fss_pkg;

    // Width of the per-segment record counter; the sums follow from it.
    localparam int COUNT_BITS = 16;
    localparam int POWER_BITS = 12;
    localparam int HEART_BITS = 8;
    localparam int SEG_BITS   = 16;
    localparam int TIME_BITS  = 32;
    localparam int MARK_BITS  = 8;

    localparam int PTOT_BITS = COUNT_BITS + POWER_BITS;
    localparam int HTOT_BITS = COUNT_BITS + HEART_BITS;

    // Both quotients fit in 16 bits, so each division needs 16 steps only.
    localparam int QUO_BITS        = 16;
    localparam int POWER_SCALE     = 4;                    // mean power x16
    localparam int HEART_PAD       = QUO_BITS - HEART_BITS;
    localparam int DVD_BITS        = COUNT_BITS + QUO_BITS;
    localparam int DIV_STEPS       = QUO_BITS;
    localparam int STEP_BITS       = $clog2(DIV_STEPS);

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [SEG_BITS-1:0]   SEG_MAX   = '1;
    localparam logic [MARK_BITS-1:0]  MARK_NONE = '0;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [TIME_BITS-1:0]  elapsed_ms;
        logic [POWER_BITS-1:0] power_watts;
        logic [HEART_BITS-1:0] heart_rate;
        logic [MARK_BITS-1:0]  marker;
        logic                  final_record;
    } t_in_item;

    typedef struct packed {
        logic [SEG_BITS-1:0]   segment_number;
        logic [TIME_BITS-1:0]  start_ms;
        logic [TIME_BITS-1:0]  end_ms;
        logic [QUO_BITS-1:0]   mean_power_x16;
        logic [HEART_BITS-1:0] mean_heart;
        logic [POWER_BITS-1:0] peak_power;
        logic [POWER_BITS-1:0] least_power;
        logic [HEART_BITS-1:0] peak_heart;
        logic [HEART_BITS-1:0] least_heart;
    } t_out_item;

    typedef struct packed {
        logic accept;    // record taken this cycle: update segment state
        logic capture;   // record closes a segment: snapshot and load divider
        logic div_step;  // advance both dividers one bit
        logic out_load;  // move finished result into the output register
    } t_dp_cmd;

    typedef struct packed {
        logic emit;      // presented record produces a result
    } t_dp_sts;

endpackage

FILE: src/fss_if.sv
// ============================================================================
// fss_if - valid/ready channels for records and segment results
// Each channel carries valid, ready and a packed payload.
// ============================================================================
interface fss_in_if;
    logic                valid;
    logic                ready;
    fss_pkg::t_in_item   payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface fss_out_if;
    logic                valid;
    logic                ready;
    fss_pkg::t_out_item  payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

FILE: src/fss_datapath.sv
// ============================================================================
// fss_datapath - segment accumulators, twin serial divider, result register
// Tracks the open segment, snapshots it on close and runs two restoring
// dividers side by side for the two means.
// ============================================================================
module fss_datapath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  fss_pkg::t_in_item  i_item,
    input  fss_pkg::t_dp_cmd   i_cmd,
    output fss_pkg::t_dp_sts   o_sts,
    output fss_pkg::t_out_item o_item
);

    // segment state
    logic                             r_open;
    logic [fss_pkg::SEG_BITS-1:0]     r_seg;
    logic [fss_pkg::TIME_BITS-1:0]    r_start;
    logic [fss_pkg::COUNT_BITS-1:0]   r_count;
    logic [fss_pkg::PTOT_BITS-1:0]    r_ptot;
    logic [fss_pkg::HTOT_BITS-1:0]    r_htot;
    logic [fss_pkg::POWER_BITS-1:0]   r_phi, r_plo;
    logic [fss_pkg::HEART_BITS-1:0]   r_hhi, r_hlo;

    logic                             n_open;
    logic [fss_pkg::SEG_BITS-1:0]     n_seg;
    logic [fss_pkg::TIME_BITS-1:0]    n_start;
    logic [fss_pkg::COUNT_BITS-1:0]   n_count;
    logic [fss_pkg::PTOT_BITS-1:0]    n_ptot;
    logic [fss_pkg::HTOT_BITS-1:0]    n_htot;
    logic [fss_pkg::POWER_BITS-1:0]   n_phi, n_plo;
    logic [fss_pkg::HEART_BITS-1:0]   n_hhi, n_hlo;

    // snapshot of a closed segment
    logic [fss_pkg::SEG_BITS-1:0]     r_p_seg;
    logic [fss_pkg::TIME_BITS-1:0]    r_p_start, r_p_end;
    logic [fss_pkg::POWER_BITS-1:0]   r_p_phi, r_p_plo;
    logic [fss_pkg::HEART_BITS-1:0]   r_p_hhi, r_p_hlo;

    // dividers: remainder, and quotient register that shifts the dividend out
    logic [fss_pkg::COUNT_BITS-1:0]   r_div;
    logic [fss_pkg::COUNT_BITS-1:0]   r_prem, r_hrem;
    logic [fss_pkg::QUO_BITS-1:0]     r_pquo, r_hquo;

    logic [fss_pkg::DVD_BITS-1:0]     w_pdvd, w_hdvd;
    logic [fss_pkg::COUNT_BITS:0]     w_ptry, w_htry;
    logic                             w_pge, w_hge;

    logic                             w_opener, w_emit, w_sat;
    logic [fss_pkg::POWER_BITS-1:0]   w_pw;
    logic [fss_pkg::HEART_BITS-1:0]   w_hr;

    fss_pkg::t_out_item               r_out;

    assign w_pw     = i_item.power_watts;
    assign w_hr     = i_item.heart_rate;
    assign w_opener = !r_open && (i_item.marker != fss_pkg::MARK_NONE);
    assign w_emit   = r_open ? ((i_item.marker == fss_pkg::MARK_NONE) || i_item.final_record)
                             : ((i_item.marker != fss_pkg::MARK_NONE) && i_item.final_record);
    assign w_sat    = (r_count == fss_pkg::COUNT_MAX);

    // next segment state for the presented record
    always_comb begin
        n_open  = !w_emit && (r_open || (i_item.marker != fss_pkg::MARK_NONE));
        n_seg   = r_seg;
        n_start = r_start;
        n_count = r_count;
        n_ptot  = r_ptot;
        n_htot  = r_htot;
        n_phi   = r_phi;
        n_plo   = r_plo;
        n_hhi   = r_hhi;
        n_hlo   = r_hlo;
        if (w_opener) begin
            if (r_seg != fss_pkg::SEG_MAX) begin
                n_seg = r_seg + 1'b1;
            end
            n_start = i_item.elapsed_ms;
            n_count = fss_pkg::COUNT_BITS'(1);
            n_ptot  = fss_pkg::PTOT_BITS'(w_pw);
            n_htot  = fss_pkg::HTOT_BITS'(w_hr);
            n_phi   = w_pw;
            n_plo   = w_pw;
            n_hhi   = w_hr;
            n_hlo   = w_hr;
        end else if (r_open) begin
            // hold count and sums once the count saturates
            if (!w_sat) begin
                n_count = r_count + 1'b1;
                n_ptot  = r_ptot + fss_pkg::PTOT_BITS'(w_pw);
                n_htot  = r_htot + fss_pkg::HTOT_BITS'(w_hr);
            end
            if (w_pw > r_phi) n_phi = w_pw;
            if (w_pw < r_plo) n_plo = w_pw;
            if (w_hr > r_hhi) n_hhi = w_hr;
            if (w_hr < r_hlo) n_hlo = w_hr;
        end
    end

    // scaled dividends; both quotients stay below 2^QUO_BITS
    assign w_pdvd = {n_ptot, {fss_pkg::POWER_SCALE{1'b0}}};
    assign w_hdvd = {n_htot, {fss_pkg::HEART_PAD{1'b0}}};

    assign w_ptry = {r_prem, r_pquo[fss_pkg::QUO_BITS-1]};
    assign w_htry = {r_hrem, r_hquo[fss_pkg::QUO_BITS-1]};
    assign w_pge  = (w_ptry >= {1'b0, r_div});
    assign w_hge  = (w_htry >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= 1'b0;
            r_seg  <= '0;
        end else if (i_cmd.accept) begin
            r_open <= n_open;
            r_seg  <= n_seg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_start <= n_start;
            r_count <= n_count;
            r_ptot  <= n_ptot;
            r_htot  <= n_htot;
            r_phi   <= n_phi;
            r_plo   <= n_plo;
            r_hhi   <= n_hhi;
            r_hlo   <= n_hlo;
        end
        if (i_cmd.capture) begin
            r_p_seg   <= n_seg;
            r_p_start <= n_start;
            r_p_end   <= i_item.elapsed_ms;
            r_p_phi   <= n_phi;
            r_p_plo   <= n_plo;
            r_p_hhi   <= n_hhi;
            r_p_hlo   <= n_hlo;
            r_div     <= n_count;
            r_prem    <= w_pdvd[fss_pkg::DVD_BITS-1:fss_pkg::QUO_BITS];
            r_pquo    <= w_pdvd[fss_pkg::QUO_BITS-1:0];
            r_hrem    <= w_hdvd[fss_pkg::DVD_BITS-1:fss_pkg::QUO_BITS];
            r_hquo    <= w_hdvd[fss_pkg::QUO_BITS-1:0];
        end else if (i_cmd.div_step) begin
            r_prem <= w_pge ? w_ptry[fss_pkg::COUNT_BITS-1:0] - r_div
                            : w_ptry[fss_pkg::COUNT_BITS-1:0];
            r_hrem <= w_hge ? w_htry[fss_pkg::COUNT_BITS-1:0] - r_div
                            : w_htry[fss_pkg::COUNT_BITS-1:0];
            r_pquo <= {r_pquo[fss_pkg::QUO_BITS-2:0], w_pge};
            r_hquo <= {r_hquo[fss_pkg::QUO_BITS-2:0], w_hge};
        end
        if (i_cmd.out_load) begin
            r_out.segment_number <= r_p_seg;
            r_out.start_ms       <= r_p_start;
            r_out.end_ms         <= r_p_end;
            r_out.mean_power_x16 <= r_pquo;
            r_out.mean_heart     <= r_hquo[fss_pkg::QUO_BITS-1:fss_pkg::HEART_PAD];
            r_out.peak_power     <= r_p_phi;
            r_out.least_power    <= r_p_plo;
            r_out.peak_heart     <= r_p_hhi;
            r_out.least_heart    <= r_p_hlo;
        end
    end

    assign o_sts.emit = w_emit;
    assign o_item     = r_out;

    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_step |-> (r_prem < r_div) && (r_hrem < r_div))
        else $error("divider remainder not below divisor");

    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_step |-> (r_div != '0))
        else $error("divide by zero count");

    a_close_clears_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.accept && w_emit) |=> !r_open)
        else $error("segment still open after its result");

endmodule

FILE: src/fss_controller.sv
// ============================================================================
// fss_controller - sequencing of record intake, division and result handoff
// Idle takes records; a closing record starts the divide pass, and the
// result moves to the output register once that register is free.
// ============================================================================
module fss_controller (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  fss_pkg::t_dp_sts  i_sts,
    output fss_pkg::t_dp_cmd  o_cmd
);

    fss_pkg::t_state                  r_state, n_state;
    logic [fss_pkg::STEP_BITS-1:0]    r_step, n_step;
    logic                             r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= fss_pkg::ST_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        o_in_ready  = 1'b0;
        o_cmd       = '0;
        // drain the output register whenever the sink takes it
        n_out_valid = r_out_valid && !i_out_ready;
        case (r_state)
            fss_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_sts.emit) begin
                        o_cmd.capture = 1'b1;
                        n_step        = '0;
                        n_state       = fss_pkg::ST_DIV;
                    end
                end
            end
            fss_pkg::ST_DIV: begin
                o_cmd.div_step = 1'b1;
                n_step         = r_step + 1'b1;
                if (r_step == fss_pkg::STEP_BITS'(fss_pkg::DIV_STEPS - 1)) begin
                    n_state = fss_pkg::ST_DONE;
                end
            end
            fss_pkg::ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = fss_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = fss_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> (!r_out_valid || i_out_ready))
        else $error("result overwritten before it was taken");

    a_capture_starts_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.capture |=> (r_state == fss_pkg::ST_DIV) && (r_step == '0))
        else $error("divide pass did not start clean");

    a_div_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.capture |=> ##(fss_pkg::DIV_STEPS) (r_state == fss_pkg::ST_DONE))
        else $error("divide pass has wrong length");

endmodule

FILE: src/flagged_segment_statistics.sv
// ============================================================================
// flagged_segment_statistics - per-segment power and heart rate statistics
// Top level: joins the controller and datapath to the record and result
// channels.
// ============================================================================
// A record with a nonzero marker, taken while no segment is open, opens a
// numbered segment; every record from that opener through the next
// zero-marker record (or the final record) is counted and folded into sums
// and extremes. Closing emits one transaction with start/end times, mean
// power x16 and mean heart rate (both truncated) and the four extremes.
// A record that produces no result leaves the block idle, so the next
// can follow immediately. A record that closes a segment occupies the
// block from its transaction to the next one: the cycle that takes it,
// then the divide pass, in which two restoring dividers run side by side,
// one quotient bit per cycle, then the move of the result into the output
// register; intake is held off until that move is done. That move waits
// further if the previous result is still unread.
// Results are held in an output register, so the sink may stall freely.
// ============================================================================
module flagged_segment_statistics (
    input  logic       i_clk,
    input  logic       i_rst_n,
    fss_in_if.sink     i_in,
    fss_out_if.source  o_out
);

    fss_pkg::t_dp_cmd   w_cmd;
    fss_pkg::t_dp_sts   w_sts;
    fss_pkg::t_out_item w_item;
    logic               w_in_ready;
    logic               w_out_valid;

    // sequencing: intake, divide pass, result handoff
    fss_controller u_ctl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (w_in_ready),
        .o_out_valid (w_out_valid),
        .i_out_ready (o_out.ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    // segment accumulators, dividers and the result register
    fss_datapath u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_in.payload),
        .i_cmd   (w_cmd),
        .o_sts   (w_sts),
        .o_item  (w_item)
    );

    assign i_in.ready    = w_in_ready;
    assign o_out.valid   = w_out_valid;
    assign o_out.payload = w_item;

endmodule
